/* hdl/gtr_pkg.sv */
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared types, constants and helpers for the gray-to-rainbow colormap.
// ----------------------------------------------------------------------------
package gtr_pkg;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_GATHER = 2'd1;
    localparam logic [1:0] MODE_MAP    = 2'd2;

    localparam int unsigned DIV_STEPS = 8;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [7:0] BAND_1 = 8'd51;
    localparam logic [7:0] BAND_2 = 8'd102;
    localparam logic [7:0] BAND_3 = 8'd153;
    localparam logic [7:0] BAND_4 = 8'd204;
    localparam logic [7:0] FULL   = 8'd255;
    localparam logic [7:0] HALF_LO = 8'd127;

    // floor(x / 102) for x below 16384, by reciprocal multiply
    localparam logic [14:0] RECIP_102 = 15'd20561;
    localparam int unsigned RECIP_SH  = 21;

    typedef struct packed {
        logic accept;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_map;
        logic div_last;
        logic out_free;
    } t_sts;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    function automatic logic [7:0] f_div102(input logic [13:0] x);
        logic [28:0] prod;
        prod = 29'(x) * 29'(RECIP_102);
        return prod[RECIP_SH +: 8];
    endfunction

endpackage

/* hdl/gtr_ctrl.sv */
// ----------------------------------------------------------------------------
// gtr_ctrl
// Sequencer: accepts items, runs the divider steps, hands off the result.
// ----------------------------------------------------------------------------
module gtr_ctrl import gtr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.emit   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid && i_sts.is_map) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/gtr_dp.sv */
// ----------------------------------------------------------------------------
// gtr_dp
// Datapath: min/max statistics, restoring divider, color bands, output stage.
// ----------------------------------------------------------------------------
module gtr_dp import gtr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_gray,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_blue,
    output logic [7:0] o_green,
    output logic [7:0] o_red
);

    logic [7:0]       r_low;
    logic [7:0]       r_high;
    logic [7:0]       r_rem;
    logic [7:0]       r_shift;
    logic [7:0]       r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic [7:0]       r_blue;
    logic [7:0]       r_green;
    logic [7:0]       r_red;

    logic             in_range;
    logic [7:0]       off;
    logic [7:0]       span;
    logic [15:0]      num;
    logic [8:0]       trial;
    logic             qbit;
    logic [7:0]       level;
    logic [7:0]       d;
    logic [7:0]       c_blue;
    logic [7:0]       c_green;
    logic [7:0]       c_red;

    assign o_sts.is_map   = (i_mode == MODE_MAP);
    assign o_sts.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_sts.out_free = !r_out_valid || i_ready;

    always_comb begin
        in_range = (r_high > r_low) && (i_gray >= r_low) && (i_gray <= r_high);
        off      = in_range ? (i_gray - r_low) : 8'd0;
        span     = in_range ? (r_high - r_low) : 8'd1;
        num      = {off, 8'd0} - {8'd0, off};
        trial    = {r_rem, r_shift[7]};
        qbit     = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= FULL;
            r_high <= 8'd0;
        end else if (i_cmd.accept) begin
            case (i_mode)
                MODE_CLEAR: begin
                    r_low  <= FULL;
                    r_high <= 8'd0;
                end
                MODE_GATHER: begin
                    if (i_gray < r_low) begin
                        r_low <= i_gray;
                    end
                    if (i_gray > r_high) begin
                        r_high <= i_gray;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.accept) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rem   <= num[15:8];
            r_shift <= num[7:0];
            r_div   <= span;
        end else if (i_cmd.step) begin
            r_rem   <= qbit ? 8'(trial - {1'b0, r_div}) : trial[7:0];
            r_shift <= {r_shift[6:0], qbit};
        end
    end

    always_comb begin
        level   = FULL - r_shift;
        d       = 8'd0;
        c_blue  = 8'd0;
        c_green = FULL;
        c_red   = 8'd0;
        if (level <= BAND_1) begin
            c_blue  = FULL;
            c_green = 8'(level * 8'd5);
        end else if (level <= BAND_2) begin
            d      = level - BAND_1;
            c_blue = FULL - 8'(d * 8'd5);
        end else if (level <= BAND_3) begin
            d     = level - BAND_2;
            c_red = 8'(d * 8'd5);
        end else if (level <= BAND_4) begin
            d       = level - BAND_3;
            c_red   = FULL;
            c_green = FULL - f_div102(14'({d, 8'd0}) + 14'd51);
        end else begin
            d       = level - BAND_4;
            c_red   = FULL;
            c_green = HALF_LO - f_div102(14'(d) * 14'd254 + 14'd51);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_blue  <= c_blue;
            r_green <= c_green;
            r_red   <= c_red;
        end
    end

    assign o_valid = r_out_valid;
    assign o_blue  = r_blue;
    assign o_green = r_green;
    assign o_red   = r_red;

endmodule

/* hdl/gray_to_rainbow_colormap.sv */
// ----------------------------------------------------------------------------
// gray_to_rainbow_colormap
// Stretches gray pixels by the gathered min/max and maps them to rainbow BGR.
// ----------------------------------------------------------------------------
// Clear and gather items give no result and can be accepted back to back.
// A map item runs 8 steps of the restoring divider, then the color is formed
// and loaded into the output stage, waiting there until that stage is free.
// The next item can be taken in the cycle after the load, not before.
// One item is in work at a time; the output stage holds a result while the
// next item is accepted. Synchronous active-low reset sets min to 255, max 0.
module gray_to_rainbow_colormap import gtr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_gray,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_blue,
    output logic [7:0] o_green,
    output logic [7:0] o_red
);

    t_cmd cmd;
    t_sts sts;

    gtr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gtr_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (i_mode),
        .i_gray  (i_gray),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_blue  (o_blue),
        .o_green (o_green),
        .o_red   (o_red)
    );

endmodule

/* test/tb_gray_to_rainbow_colormap.sv */
// ----------------------------------------------------------------------------
// tb_gray_to_rainbow_colormap
// Self-checking bench for the gray-to-rainbow colormap. A queue of clear,
// gather and map items feeds a bursty driver. Each accepted clear or gather
// item updates a local min/max copy, and each map item queues the expected
// blue/green/red. A monitor checks every result against that queue while the
// receiver stalls on a varying pattern, with one long hold-off to back up the block.
// ----------------------------------------------------------------------------
module tb_gray_to_rainbow_colormap;
    import gtr_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int RST_CYCLES   = 6;
    localparam int TARGET_ITEMS = 450;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 2500;
    localparam int TAIL_CYCLES  = 30;
    localparam int PRINT_CAP    = 60;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] gray;
    } t_pixel_item;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_bgr;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_mode  = MODE_CLEAR;
    logic [7:0] i_gray  = 8'd0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_blue;
    logic [7:0] o_green;
    logic [7:0] o_red;

    t_pixel_item pending_q[$];
    t_bgr        color_due[$];
    t_pixel_item next_px;

    logic [7:0] lo_px = 8'd255;
    logic [7:0] hi_px = 8'd0;

    bit in_run      = 1'b0;
    bit in_took     = 1'b0;
    bit out_took    = 1'b0;
    bit hold_done   = 1'b0;
    int n_queued    = 0;
    int n_counted   = 0;
    int n_taken     = 0;
    int n_results   = 0;
    int n_errors    = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    int hold_left   = 0;
    int rx_cycle    = 0;

    gray_to_rainbow_colormap DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_mode  (i_mode),
        .i_gray  (i_gray),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_blue  (o_blue),
        .o_green (o_green),
        .o_red   (o_red)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        if (n_errors < PRINT_CAP) begin
            $display("%0t ERROR %s", $time, msg);
        end
        n_errors++;
    endtask

    function automatic int unsigned level_of(input logic [7:0] g);
        int unsigned span;
        int unsigned offs;
        if (hi_px <= lo_px) begin
            return 255;
        end
        span = hi_px - lo_px;
        offs = (g >= lo_px && g <= hi_px) ? (g - lo_px) : 0;
        return 255 - (offs * 255) / span;
    endfunction

    function automatic t_bgr rainbow_of(input int unsigned lvl);
        t_bgr        c;
        int unsigned d;
        if (lvl <= BAND_1) begin
            c.blue = 8'd255; c.green = 8'(lvl * 5); c.red = 8'd0;
        end else if (lvl <= BAND_2) begin
            d = lvl - BAND_1;
            c.blue = 8'(255 - d * 5); c.green = 8'd255; c.red = 8'd0;
        end else if (lvl <= BAND_3) begin
            d = lvl - BAND_2;
            c.blue = 8'd0; c.green = 8'd255; c.red = 8'(d * 5);
        end else if (lvl <= BAND_4) begin
            d = lvl - BAND_3;
            c.blue = 8'd0; c.green = 8'(255 - (d * 256 + 51) / 102); c.red = 8'd255;
        end else begin
            d = lvl - BAND_4;
            c.blue = 8'd0; c.green = 8'(127 - (d * 254 + 51) / 102); c.red = 8'd255;
        end
        return c;
    endfunction

    task automatic absorb_item(input logic [1:0] md, input logic [7:0] g);
        case (md)
            MODE_CLEAR: begin
                lo_px = 8'd255;
                hi_px = 8'd0;
            end
            MODE_GATHER: begin
                if (g < lo_px) lo_px = g;
                if (g > hi_px) hi_px = g;
            end
            MODE_MAP: begin
                color_due.push_back(rainbow_of(level_of(g)));
            end
            default: begin
            end
        endcase
    endtask

    task automatic queue_item(input logic [1:0] md, input logic [7:0] g);
        pending_q.push_back('{mode: md, gray: g});
        n_queued++;
        if (md != MODE_SPARE) n_counted++;
    endtask

    // monitor, predictor update and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_run   = 1'b1;
            in_took  = i_valid && o_ready;
            out_took = o_valid && i_ready;
            if (out_took) begin
                n_results++;
                if (color_due.size() == 0) begin
                    report_error($sformatf("result with none pending: b=%0d g=%0d r=%0d",
                                           o_blue, o_green, o_red));
                end else begin
                    t_bgr want;
                    want = color_due.pop_front();
                    if (o_blue !== want.blue)
                        report_error($sformatf("result %0d blue got %0d want %0d",
                                               n_results, o_blue, want.blue));
                    if (o_green !== want.green)
                        report_error($sformatf("result %0d green got %0d want %0d",
                                               n_results, o_green, want.green));
                    if (o_red !== want.red)
                        report_error($sformatf("result %0d red got %0d want %0d",
                                               n_results, o_red, want.red));
                end
            end
            if (in_took) begin
                n_taken++;
                absorb_item(i_mode, i_gray);
            end
            if (in_took || out_took) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t watchdog: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("tb_gray_to_rainbow_colormap: done, errors");
                $finish;
            end
        end
    end

    // sender: bursts with random gaps
    always @(negedge i_clk) begin
        if (in_run && (!i_valid || in_took)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                next_px = pending_q.pop_front();
                i_mode  <= next_px.mode;
                i_gray  <= next_px.gray;
                i_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: phased stall pattern plus one long hold-off
    always @(negedge i_clk) begin
        rx_cycle++;
        if (!hold_done && n_results >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            case ((rx_cycle / 50) % 4)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom_range(0, 1));
                2: i_ready <= (rx_cycle % 4 == 0);
                default: i_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    initial begin
        int lo_g;
        int hi_g;
        int base;
        int spread;
        int v;
        int sel;

        // empty range, spare mode ignored
        queue_item(MODE_MAP, 8'd0);
        queue_item(MODE_MAP, 8'd255);
        queue_item(MODE_SPARE, 8'hAA);
        queue_item(MODE_SPARE, 8'h55);
        // full range: extremes and band edges
        queue_item(MODE_GATHER, 8'd255);
        queue_item(MODE_GATHER, 8'd0);
        queue_item(MODE_MAP, 8'd0);
        queue_item(MODE_MAP, 8'd255);
        queue_item(MODE_MAP, 8'd51);
        queue_item(MODE_MAP, 8'd102);
        queue_item(MODE_MAP, 8'd153);
        queue_item(MODE_MAP, 8'd204);
        queue_item(MODE_MAP, 8'd128);
        // single-value range
        queue_item(MODE_CLEAR, 8'd0);
        queue_item(MODE_GATHER, 8'd100);
        queue_item(MODE_MAP, 8'd100);
        // pixels below, inside and above the range, and on its edges
        queue_item(MODE_GATHER, 8'd50);
        queue_item(MODE_GATHER, 8'd200);
        queue_item(MODE_MAP, 8'd20);
        queue_item(MODE_MAP, 8'd220);
        queue_item(MODE_MAP, 8'd125);
        queue_item(MODE_MAP, 8'd50);
        queue_item(MODE_MAP, 8'd200);
        queue_item(MODE_CLEAR, 8'd255);

        while (n_counted < TARGET_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
                if ($urandom_range(0, 4) != 0) queue_item(MODE_CLEAR, 8'($urandom));
                base = $urandom_range(0, 255);
                sel  = $urandom_range(0, 2);
                spread = (sel == 0) ? $urandom_range(0, 3) :
                         (sel == 1) ? $urandom_range(4, 40) : 255;
                lo_g = 255;
                hi_g = 0;
                repeat ($urandom_range(1, 6)) begin
                    v = base + $urandom_range(0, spread);
                    if (v > 255) v = 255;
                    if (v < lo_g) lo_g = v;
                    if (v > hi_g) hi_g = v;
                    queue_item(MODE_GATHER, 8'(v));
                end
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 4) != 0) v = $urandom_range(lo_g, hi_g);
                    else v = $urandom_range(0, 255);
                    queue_item(MODE_MAP, 8'(v));
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    queue_item(2'($urandom_range(0, 3)), 8'($urandom));
            end
        end

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken < n_queued) @(posedge i_clk);
        while (color_due.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_gray_to_rainbow_colormap: done, clean");
        end else begin
            $display("tb_gray_to_rainbow_colormap: done, errors");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/gtr_pkg.sv
hdl/gtr_ctrl.sv
hdl/gtr_dp.sv
hdl/gray_to_rainbow_colormap.sv
test/tb_gray_to_rainbow_colormap.sv
